// File: rtl/core/pbdq_pkg.sv
// Packed band dequantizer: shared constants, types and helper functions.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package pbdq_pkg;

  localparam int unsigned MAX_COEFFS  = 128;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned BUF_W       = 12;
  localparam int unsigned HELD_W      = 4;
  localparam int unsigned CODE_W      = 5;
  localparam int unsigned WIDTH_W     = 3;
  localparam int unsigned BIAS_W      = 4;
  localparam int unsigned SCALE_W     = 32;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned COEFF_W     = 38;
  localparam int unsigned DIFF_W      = 6;
  localparam int unsigned STEP_W      = 2;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [WIDTH_W-1:0] MIN_WIDTH = 3'd2;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_WIDTH   = 2'd0,
    REG_SIGN_BIAS    = 2'd1,
    REG_SCALE_FACTOR = 2'd2,
    REG_COEFF_COUNT  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] code_width;
    logic [BIAS_W-1:0]  sign_bias;
    logic [SCALE_W-1:0] scale_factor;
    logic [COUNT_W-1:0] coeff_count;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } code_entry_t;

  typedef struct packed {
    logic              busy;
    logic [HELD_W-1:0] held;
  } front_status_t;

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] r;
    r = w;
    if (w < MIN_WIDTH) r = MIN_WIDTH;
    if (w > MAX_WIDTH) r = MAX_WIDTH;
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] r;
    r = n;
    if (n == '0) r = COUNT_W'(1);
    if (n > COUNT_W'(MAX_COEFFS)) r = COUNT_W'(MAX_COEFFS);
    return r;
  endfunction

endpackage

// File: rtl/core/packed_band_dequantizer_top.sv
// Packed band dequantizer top level: config registers, front end, code queue, back end.
// Depends on pbdq_pkg, pbdq_front, pbdq_queue and pbdq_back.
//
//   channel | signals                                  | request moves
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//   in      | in_valid, in_stall, packed_byte          | one packed byte
//   out     | out_valid, out_stall, coefficient,       | one coefficient
//           | band_last                                |
//
// The front end splits off one code per cycle while the queue is not full; a byte yields
// 4 codes at 2-bit codes, 1 or 2 at 5-bit, always at least one; the next byte is taken
// in the cycle of the last code. A code passes the queue, s1 and the output register.
// Reset clears control state, the bit buffer and the band counter; cfg_ready is
// always high. out_stall holds the output register; the queue then fills and stalls in.
`timescale 1ns / 1ps

module packed_band_dequantizer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pbdq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbdq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          packed_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [37:0]                  coefficient,
  output logic                                band_last
);
  import pbdq_pkg::*;

  cfg_t          cfg;
  code_entry_t   push_entry;
  code_entry_t   pop_entry;
  front_status_t front_st;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_nonempty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_width   <= WIDTH_W'(5);
      cfg.sign_bias    <= BIAS_W'(15);
      cfg.scale_factor <= SCALE_W'(16777216);
      cfg.coeff_count  <= COUNT_W'(MAX_COEFFS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_CODE_WIDTH:   cfg.code_width   <= cfg_data[WIDTH_W-1:0];
        REG_SIGN_BIAS:    cfg.sign_bias    <= cfg_data[BIAS_W-1:0];
        REG_SCALE_FACTOR: cfg.scale_factor <= cfg_data[SCALE_W-1:0];
        REG_COEFF_COUNT:  cfg.coeff_count  <= cfg_data[COUNT_W-1:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  pbdq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .packed_byte (packed_byte),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full),
    .status      (front_st)
  );

  pbdq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .nonempty   (q_nonempty)
  );

  pbdq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .nonempty    (q_nonempty),
    .pop_entry   (pop_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .coefficient (coefficient),
    .band_last   (band_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("code pushed into a full queue");

  a_idle_held: assert property (@(posedge clk) disable iff (rst)
    !front_st.busy |-> front_st.held <= HELD_W'(4))
    else $error("more than four bits held between bytes");

  a_band_flush: assert property (@(posedge clk) disable iff (rst)
    push && push_entry.last && !(in_valid && !in_stall)
    |=> !front_st.busy && front_st.held == '0)
    else $error("bits kept after band end");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

// File: rtl/core/pbdq_front.sv
// Front end (depends on pbdq_pkg): takes packed bytes into the bit buffer, splits off
// one code per cycle unless the queue is full; tracks band position, marks its last code.
`timescale 1ns / 1ps

module pbdq_front (
  input  logic                    clk,
  input  logic                    rst,
  input  pbdq_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              packed_byte,
  output logic                    push,
  output pbdq_pkg::code_entry_t   push_entry,
  input  logic                    q_full,
  output pbdq_pkg::front_status_t status
);
  import pbdq_pkg::*;

  logic [BUF_W-1:0]   bit_buffer;
  logic [HELD_W-1:0]  bits_held;
  logic [COUNT_W-1:0] coeffs_done;
  logic [STEP_W-1:0]  step_count;
  logic               busy;

  logic [WIDTH_W-1:0] w;
  logic [COUNT_W-1:0] n;
  logic [CODE_W-1:0]  mask;
  logic [CODE_W-1:0]  code;
  logic [BUF_W-1:0]   buf_shift;
  logic [HELD_W-1:0]  held_sub;
  logic [COUNT_W-1:0] done_inc;
  logic               last;
  logic               ext;
  logic               more;
  logic               accept;
  logic [BUF_W-1:0]   buf_rem;
  logic [HELD_W-1:0]  held_rem;
  logic [COUNT_W-1:0] done_rem;
  logic [BUF_W-1:0]   base_buf;
  logic [HELD_W-1:0]  base_held;
  logic [BUF_W-1:0]   bit_buffer_next;
  logic [HELD_W-1:0]  bits_held_next;
  logic [COUNT_W-1:0] coeffs_done_next;

  always_comb begin
    w         = eff_width(cfg.code_width);
    n         = eff_count(cfg.coeff_count);
    mask      = CODE_W'((6'd1 << w) - 6'd1);
    code      = bit_buffer[CODE_W-1:0] & mask;
    buf_shift = bit_buffer >> w;
    held_sub  = bits_held - HELD_W'(w);
    done_inc  = coeffs_done + COUNT_W'(1);
    last      = (done_inc >= n);
    ext       = busy && !q_full;
    more      = !last && (held_sub >= HELD_W'(w)) &&
                (step_count != STEP_W'(MAX_RESULTS - 1));
    buf_rem   = last ? '0 : buf_shift;
    held_rem  = last ? '0 : held_sub;
    done_rem  = last ? '0 : done_inc;
    base_buf  = ext ? buf_rem : bit_buffer;
    base_held = ext ? held_rem : bits_held;
    in_stall  = busy && !(ext && !more);
    accept    = in_valid && !in_stall;

    bit_buffer_next  = base_buf | (BUF_W'(packed_byte) << base_held);
    bits_held_next   = base_held + HELD_W'(BYTE_BITS);
    coeffs_done_next = ext ? done_rem : coeffs_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer  <= '0;
      bits_held   <= '0;
      coeffs_done <= '0;
      step_count  <= '0;
      busy        <= 1'b0;
    end else if (accept) begin
      bit_buffer  <= bit_buffer_next;
      bits_held   <= bits_held_next;
      coeffs_done <= coeffs_done_next;
      step_count  <= '0;
      busy        <= 1'b1;
    end else if (ext) begin
      bit_buffer  <= buf_rem;
      bits_held   <= held_rem;
      coeffs_done <= done_rem;
      step_count  <= step_count + STEP_W'(1);
      busy        <= more;
    end
  end

  assign push            = ext;
  assign push_entry.code = code;
  assign push_entry.last = last;
  assign status.busy     = busy;
  assign status.held     = bits_held;

endmodule

// File: rtl/core/pbdq_queue.sv
// Short code queue between the front end and the multiply back end.
// Four entries of code plus band-end flag. Depends on pbdq_pkg.
`timescale 1ns / 1ps

module pbdq_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pbdq_pkg::code_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output pbdq_pkg::code_entry_t pop_entry,
  output logic                  nonempty
);
  import pbdq_pkg::*;

  code_entry_t       entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign nonempty  = (count != '0);
  assign pop_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      priority if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end else begin
        count <= count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

endmodule

// File: rtl/core/pbdq_back.sv
// Back end: removes the bias, multiplies by the Q8.24 scale and holds the result.
// Two stages with an output register; depends on pbdq_pkg.
`timescale 1ns / 1ps

module pbdq_back (
  input  logic                  clk,
  input  logic                  rst,
  input  pbdq_pkg::cfg_t        cfg,
  input  logic                  nonempty,
  input  pbdq_pkg::code_entry_t pop_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [37:0]    coefficient,
  output logic                  band_last
);
  import pbdq_pkg::*;

  logic                      s1_valid;
  logic signed [DIFF_W-1:0]  s1_diff;
  logic                      s1_last;
  logic signed [DIFF_W-1:0]  diff_next;
  logic signed [COEFF_W-1:0] coefficient_next;
  logic                      adv_out;
  logic                      s1_load;

  always_comb begin
    adv_out          = !out_valid || !out_stall;
    s1_load          = !s1_valid || adv_out;
    pop              = nonempty && s1_load;
    diff_next        = $signed({1'b0, pop_entry.code}) - $signed(DIFF_W'(cfg.sign_bias));
    coefficient_next = COEFF_W'(s1_diff) * COEFF_W'($signed(cfg.scale_factor));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= pop;
      if (adv_out) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_diff <= diff_next;
      s1_last <= pop_entry.last;
    end
    if (adv_out && s1_valid) begin
      coefficient <= coefficient_next;
      band_last   <= s1_last;
    end
  end

endmodule
